@@ rtl/core/cdps_pkg.sv @@
// Shared types and constants for the clock divider pair search block.
// No dependencies; imported by clock_divider_pair_search.
`default_nettype none

package cdps_pkg;

  // Field widths of the stream and register payloads
  localparam int TARGET_W    = 22;
  localparam int BASE_W      = 27;
  localparam int DIV_OUT_W   = 6;
  localparam int ERR_W       = 30;
  localparam int FRAC_W      = 8;
  localparam int PRESCALE_SH = 5;   // base clock is divided by 32

  // Byte-padded stream data widths
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  // APB side
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam logic [APB_ADDR_W-3:0] REG_BASE_CLOCK = '0;

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(104000000);

  // Default search range: dividers 1 .. DIVIDER_LIMIT_DEF-1
  localparam int DIVIDER_LIMIT_DEF = 64;

  // Shared divider: quotient bits resolved per cycle, and cycles per divide
  localparam int QBITS_PER_CYC = 3;
  localparam int DIV_CYCLES    = ERR_W / QBITS_PER_CYC;
  localparam int CNT_W         = $clog2(DIV_CYCLES);

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_HOLD = 4'b1000
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/clock_divider_pair_search.sv @@
// Divider pair search: finds (i, j) whose rate (base/32)/(i*j) is closest to a target.
// Depends on cdps_pkg (widths, state encoding, divider step constants).
`default_nettype none
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+------------------------------------------
//  in_      | in  | in_tvalid / in_tready        | in_tdata: target_rate
//  out_     | out | out_tvalid / out_tready      | out_tdata: bit/master divider, best_error
//  cfg (APB)| in  | psel, penable, pwrite, pready| base_clock_hz at byte address 0
//
//  Each item searches P = (L-1)*L/2 divider pairs (j >= i) for L = DIVIDER_LIMIT; each
//  pair runs through the single shared restoring divider, 3 quotient bits per cycle,
//  and then through one compare step. Divisors i*j are formed by running adds.
//  in_tready is high only in idle; one finished result may wait in the output register.
//  Reset (rst_n low, synchronous) returns to idle, drops out_tvalid, reloads base clock.

module clock_divider_pair_search #(
  parameter int DIVIDER_LIMIT = cdps_pkg::DIVIDER_LIMIT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // stream in
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [cdps_pkg::IN_TDATA_W-1:0]     in_tdata,   // [21:0] target_rate
  // stream out
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [cdps_pkg::OUT_TDATA_W-1:0]         out_tdata,  // [5:0] bit_clock_divider,
                                                               // [11:6] master_clock_divider,
                                                               // [41:12] best_error
  // APB config
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [cdps_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [cdps_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [cdps_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                     pready
);
  import cdps_pkg::*;

  localparam int IW = (DIVIDER_LIMIT > 2) ? $clog2(DIVIDER_LIMIT) : 1;
  localparam int PW = 2 * IW;
  localparam logic [IW-1:0]    I_LAST   = IW'(DIVIDER_LIMIT - 1);
  localparam logic [IW-1:0]    I_ONE    = IW'(1);
  localparam logic [PW-1:0]    P_ONE    = PW'(1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_CYCLES - 1);
  localparam int OUT_PAD = OUT_TDATA_W - 2 * DIV_OUT_W - ERR_W;

  state_t state_r, state_nxt;

  logic [BASE_W-1:0]      base_r, base_nxt;
  logic [ERR_W-1:0]       num_r, num_nxt;
  logic [ERR_W-1:0]       want_r, want_nxt;
  logic [IW-1:0]          i_r, i_nxt, j_r, j_nxt;
  logic [PW-1:0]          p_r, p_nxt, sq_r, sq_nxt;
  logic [PW-1:0]          rem_r, rem_nxt;
  logic [ERR_W-1:0]       dq_r, dq_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [ERR_W-1:0]       best_r, best_nxt;
  logic [IW-1:0]          bi_r, bi_nxt, bj_r, bj_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  logic [ERR_W-1:0]       start_num;
  logic [ERR_W-1:0]       err;
  logic [PW-1:0]          rem_step;
  logic [ERR_W-1:0]       dq_step;
  logic                   cfg_wr;
  logic                   in_beat;
  logic                   out_free;

  // APB register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[APB_ADDR_W-1:2] == REG_BASE_CLOCK);
  assign prdata = (paddr[APB_ADDR_W-1:2] == REG_BASE_CLOCK) ? APB_DATA_W'(base_r) : '0;
  assign base_nxt = cfg_wr ? pwdata[BASE_W-1:0] : base_r;

  // Handshakes
  assign in_tready  = (state_r == ST_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;

  // Scaled base in 8-bit fixed point: floor(base/32) << 8
  assign start_num = {base_r[BASE_W-1:PRESCALE_SH], {FRAC_W{1'b0}}};

  // Shared restoring divider: QBITS_PER_CYC quotient bits per cycle
  always_comb begin
    logic [PW:0] trial;
    rem_step = rem_r;
    dq_step  = dq_r;
    for (int k = 0; k < QBITS_PER_CYC; k++) begin
      trial   = {rem_step, dq_step[ERR_W-1]};
      dq_step = {dq_step[ERR_W-2:0], 1'b0};
      if (trial >= {1'b0, p_r}) begin
        rem_step   = PW'(trial - {1'b0, p_r});
        dq_step[0] = 1'b1;
      end else begin
        rem_step = trial[PW-1:0];
      end
    end
  end

  // Exact absolute error of the finished quotient
  assign err = (dq_r >= want_r) ? (dq_r - want_r) : (want_r - dq_r);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    want_nxt      = want_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    p_nxt         = p_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    dq_nxt        = dq_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    bi_nxt        = bi_r;
    bj_nxt        = bj_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          num_nxt   = start_num;
          want_nxt  = {in_tdata[TARGET_W-1:0], {FRAC_W{1'b0}}};
          i_nxt     = I_ONE;
          j_nxt     = I_ONE;
          p_nxt     = P_ONE;
          sq_nxt    = P_ONE;
          rem_nxt   = '0;
          dq_nxt    = start_num;
          cnt_nxt   = '0;
          best_nxt  = start_num;
          bi_nxt    = I_ONE;
          bj_nxt    = I_ONE;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt = rem_step;
        dq_nxt  = dq_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        // strictly smaller error replaces the best, so earlier pairs win ties
        if (err < best_r) begin
          best_nxt = err;
          bi_nxt   = i_r;
          bj_nxt   = j_r;
        end
        rem_nxt = '0;
        dq_nxt  = num_r;
        cnt_nxt = '0;
        if (j_r != I_LAST) begin
          j_nxt     = j_r + 1'b1;
          p_nxt     = p_r + PW'(i_r);
          state_nxt = ST_DIV;
        end else if (i_r != I_LAST) begin
          // next row starts on the diagonal: (i+1)^2 = i^2 + 2i + 1
          i_nxt     = i_r + 1'b1;
          j_nxt     = i_r + 1'b1;
          sq_nxt    = sq_r + PW'({i_r, 1'b1});
          p_nxt     = sq_r + PW'({i_r, 1'b1});
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{OUT_PAD{1'b0}}, best_r,
                           DIV_OUT_W'(bj_r), DIV_OUT_W'(bi_r)};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      base_r      <= BASE_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      base_r      <= base_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    num_r      <= num_nxt;
    want_r     <= want_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    p_r        <= p_nxt;
    sq_r       <= sq_nxt;
    rem_r      <= rem_nxt;
    dq_r       <= dq_nxt;
    cnt_r      <= cnt_nxt;
    best_r     <= best_nxt;
    bi_r       <= bi_nxt;
    bj_r       <= bj_nxt;
    out_data_r <= out_data_nxt;
  end

  // Checks
  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (j_r >= i_r))
    else $error("divider pair out of order");

  a_divisor_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (32'(p_r) == 32'(i_r) * 32'(j_r)))
    else $error("running divisor differs from i*j");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < p_r))
    else $error("divider remainder not below divisor");

  a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[DIV_OUT_W-1:0] <= out_tdata[2*DIV_OUT_W-1:DIV_OUT_W]))
    else $error("result dividers out of order");

endmodule

`default_nettype wire
